@@ rtl/assert_macros.svh @@
// Assertion helpers for the archive block.
// Each use states a label, a property body and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define TKRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TKRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/tkra_pkg.sv @@
// ----------------------------------------------------------------------------
// tkra_pkg
// Shared types and codes of the ranked archive: operation and status codes,
// the controller command word and the result word.
// ----------------------------------------------------------------------------
package tkra_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_OFFER = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes of a result word.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_RANK = 1'b1;

    // Size of the archive after reset.
    localparam logic [6:0] RESET_ACTIVE_SIZE = 7'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture an accepted input word
        logic eval;    // compare all entries, first read-select stage
        logic commit;  // shift entries, second read-select stage, write result
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic               status;
        logic               accepted;
        logic [5:0]         insert_rank;
        logic               evicted_valid;
        logic [15:0]        evicted_payload;
        logic signed [31:0] best_fitness;
        logic [15:0]        best_payload;
        logic signed [31:0] read_fitness;
        logic [15:0]        read_payload;
        logic [6:0]         entry_count;
    } t_result;

endpackage

@@ rtl/top_k_ranked_archive_core.sv @@
// ----------------------------------------------------------------------------
// top_k_ranked_archive_core
// Rank-ordered archive of the best candidates of a search, with offer,
// clear and read-by-rank operations and a report of the best entry.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  input     in         i_valid / o_ready         operation, fitness, payload, rank
//  result    out        o_valid / i_ready         status, offer, best, read, count
//  config    in         i_cfg_valid / o_cfg_ready active_size
//
// Each word passes through capture, evaluate (compare of every cell
// and first read-select stage), commit (shift and second read-select stage).
// The next word can be taken in the cycle after the result is registered, unless a configuration write goes first.
// If the previous result has not been taken, commit waits and the word stalls.
// Synchronous active-low reset clears the fill count and sets the size to 16;
// entries need no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module top_k_ranked_archive_core #(
    parameter int MAX_ENTRIES  = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_fitness,
    input  logic [15:0]        i_payload,
    input  logic [5:0]         i_read_rank,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output logic               o_accepted,
    output logic [5:0]         o_insert_rank,
    output logic               o_evicted_valid,
    output logic [15:0]        o_evicted_payload,
    output logic signed [31:0] o_best_fitness,
    output logic [15:0]        o_best_payload,
    output logic signed [31:0] o_read_fitness,
    output logic [15:0]        o_read_payload,
    output logic [6:0]         o_entry_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_active_size
);

    tkra_pkg::t_cmd    w_cmd;
    tkra_pkg::t_result w_res;
    logic              w_cfg_we;

    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    // Sequencer.
    tkra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_out_ready (i_ready),
        .o_ready     (o_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    // Cell row and result register.
    tkra_datapath #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_active_size (i_cfg_active_size),
        .i_operation       (i_operation),
        .i_fitness         (i_fitness),
        .i_payload         (i_payload),
        .i_read_rank       (i_read_rank),
        .o_result          (w_res)
    );

    assign o_status          = w_res.status;
    assign o_accepted        = w_res.accepted;
    assign o_insert_rank     = w_res.insert_rank;
    assign o_evicted_valid   = w_res.evicted_valid;
    assign o_evicted_payload = w_res.evicted_payload;
    assign o_best_fitness    = w_res.best_fitness;
    assign o_best_payload    = w_res.best_payload;
    assign o_read_fitness    = w_res.read_fitness;
    assign o_read_payload    = w_res.read_payload;
    assign o_entry_count     = w_res.entry_count;

    // A captured word blocks the input side until its commit.
    `TKRA_ASSERT(a_one_in_flight, (i_valid && o_ready) |=> !o_ready, "second word taken while busy")
    // A rejected or non-offer word reports no placement and no eviction.
    `TKRA_ASSERT(a_no_offer_fields, (o_valid && !o_accepted) |-> (o_insert_rank == 6'd0 && !o_evicted_valid), "offer fields set without placement")
    // A bad read leaves the read fields at zero.
    `TKRA_ASSERT(a_bad_read_zero, (o_valid && o_status) |-> (o_read_fitness == 32'sd0 && o_read_payload == 16'd0 && !o_accepted), "bad read with data")
    // An empty archive reports a zero best entry.
    `TKRA_ASSERT(a_empty_best_zero, (o_valid && o_entry_count == 7'd0) |-> (o_best_fitness == 32'sd0 && o_best_payload == 16'd0), "best entry of empty archive")

endmodule

@@ rtl/tkra_ctrl.sv @@
// ----------------------------------------------------------------------------
// tkra_ctrl
// Sequencer of the ranked archive: accepts a word, steps the datapath
// through evaluate and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tkra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_cfg_valid,
    input  logic           i_out_ready,
    output logic           o_ready,
    output logic           o_cfg_ready,
    output logic           o_out_valid,
    output tkra_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_commit;

    // A configuration write takes precedence over an input word in idle.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;

    // The result register may be refilled once it is empty or being taken.
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_cmd.load   = o_ready && i_valid;
    assign o_cmd.eval   = (r_state == S_EVAL);
    assign o_cmd.commit = w_commit;
    assign o_out_valid  = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_ready && i_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_commit) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/tkra_datapath.sv @@
// ----------------------------------------------------------------------------
// tkra_datapath
// Row of archive cells with parallel compare and shift, a two-stage
// registered read select, the fill count, the size register and the
// result register.
// ----------------------------------------------------------------------------
module tkra_datapath #(
    parameter int MAX_ENTRIES  = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkra_pkg::t_cmd     i_cmd,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_active_size,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_fitness,
    input  logic [15:0]        i_payload,
    input  logic [5:0]         i_read_rank,
    output tkra_pkg::t_result  o_result
);

    // Count width, and a common width for size and rank compares.
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = (CW > 7) ? CW : 7;
    // Read select: groups of eight cells, then one group.
    localparam int NG = (MAX_ENTRIES + 7) / 8;

    // Effective archive size: zero acts as one, large values clamp.
    function automatic logic [SW-1:0] eff_size(input logic [6:0] a);
        logic [SW-1:0] w;
        w = SW'(a);
        if (w == '0) begin
            w = SW'(1);
        end else if (w > SW'(MAX_ENTRIES)) begin
            w = SW'(MAX_ENTRIES);
        end
        return w;
    endfunction

    // Control state.
    logic [6:0]              r_active_size;
    logic [CW-1:0]           r_filled;
    logic [CW-1:0]           n_filled;

    // Archive cells.
    logic signed [31:0]      r_fit [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] r_pay [MAX_ENTRIES];

    // Captured input word.
    logic [1:0]              r_op;
    logic signed [31:0]      r_cand_fit;
    logic [PAYLOAD_BITS-1:0] r_cand_pay;
    logic [5:0]              r_rr;

    // Evaluate stage.
    logic [MAX_ENTRIES-1:0]  r_le;
    logic signed [31:0]      r_grp_fit [NG];
    logic [PAYLOAD_BITS-1:0] r_grp_pay [NG];
    logic [SW-4:0]           r_gidx;

    tkra_pkg::t_result       r_res;
    tkra_pkg::t_result       n_res;

    logic [SW-1:0]           w_k;
    logic [SW-1:0]           w_addr;
    logic [CW-1:0]           w_pos;
    logic                    w_full;
    logic                    w_do_ins;
    logic [SW-1:0]           w_last;
    logic                    w_rd_ok;
    logic signed [31:0]      w_sel_fit;
    logic [PAYLOAD_BITS-1:0] w_sel_pay;
    logic signed [31:0]      w_best_fit;
    logic [PAYLOAD_BITS-1:0] w_best_pay;

    assign w_k = eff_size(r_active_size);

    // Offers read the worst kept entry, reads the requested rank.
    assign w_addr = (r_op == tkra_pkg::OP_OFFER) ? (w_k - SW'(1)) : SW'(r_rr);

    // Entries are sorted, so the count of entries not worse than the
    // candidate is its insertion rank.
    assign w_pos    = CW'($countones(r_le));
    assign w_full   = SW'(r_filled) >= w_k;
    assign w_do_ins = (r_op == tkra_pkg::OP_OFFER) && (!w_full || (SW'(w_pos) < w_k));
    assign w_last   = w_full ? (w_k - SW'(1)) : SW'(r_filled);
    assign w_rd_ok  = SW'(r_rr) < SW'(r_filled);

    // Second read-select stage: pick one group.
    always_comb begin
        w_sel_fit = r_grp_fit[0];
        w_sel_pay = r_grp_pay[0];
        for (int g = 0; g < NG; g++) begin
            if (r_gidx == (SW-3)'(g)) begin
                w_sel_fit = r_grp_fit[g];
                w_sel_pay = r_grp_pay[g];
            end
        end
    end

    // Fill count after the step.
    always_comb begin
        n_filled = r_filled;
        if (r_op == tkra_pkg::OP_CLEAR) begin
            n_filled = '0;
        end else if (w_do_ins && !w_full) begin
            n_filled = r_filled + CW'(1);
        end
    end

    // Rank-zero entry after the step.
    always_comb begin
        w_best_fit = r_fit[0];
        w_best_pay = r_pay[0];
        if (w_do_ins && (w_pos == '0)) begin
            w_best_fit = r_cand_fit;
            w_best_pay = r_cand_pay;
        end
    end

    // Result word.
    always_comb begin
        n_res                 = '0;
        n_res.status          = tkra_pkg::STATUS_OK;
        n_res.entry_count     = 7'(n_filled);
        if (w_do_ins) begin
            n_res.accepted    = 1'b1;
            n_res.insert_rank = 6'(w_pos);
            if (w_full) begin
                n_res.evicted_valid   = 1'b1;
                n_res.evicted_payload = 16'(w_sel_pay);
            end
        end
        if (r_op == tkra_pkg::OP_READ) begin
            if (w_rd_ok) begin
                n_res.read_fitness = w_sel_fit;
                n_res.read_payload = 16'(w_sel_pay);
            end else begin
                n_res.status = tkra_pkg::STATUS_BAD_RANK;
            end
        end
        if (n_filled != '0) begin
            n_res.best_fitness = w_best_fit;
            n_res.best_payload = 16'(w_best_pay);
        end
    end

    // Size register and fill count; shrinking the size drops the worst entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= tkra_pkg::RESET_ACTIVE_SIZE;
            r_filled      <= '0;
        end else if (i_cfg_we) begin
            r_active_size <= i_cfg_active_size;
            if (SW'(r_filled) > eff_size(i_cfg_active_size)) begin
                r_filled <= CW'(eff_size(i_cfg_active_size));
            end
        end else if (i_cmd.commit) begin
            r_filled <= n_filled;
        end
    end

    // Input capture, evaluate stage and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_cand_fit <= i_fitness;
            r_cand_pay <= PAYLOAD_BITS'(i_payload);
            r_rr       <= i_read_rank;
        end
        if (i_cmd.eval) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_le[i] <= (SW'(i) < SW'(r_filled)) && (r_fit[i] <= r_cand_fit);
            end
            for (int g = 0; g < NG; g++) begin
                for (int j = 0; j < 8; j++) begin
                    if ((g * 8 + j < MAX_ENTRIES) && (w_addr[2:0] == 3'(j))) begin
                        r_grp_fit[g] <= r_fit[g * 8 + j];
                        r_grp_pay[g] <= r_pay[g * 8 + j];
                    end
                end
            end
            r_gidx <= w_addr[SW-1:3];
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    // Cell row: hold above the insertion rank, take the candidate at it,
    // take the better neighbor below it down to the last kept entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_do_ins) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (CW'(i) == w_pos) begin
                    r_fit[i] <= r_cand_fit;
                    r_pay[i] <= r_cand_pay;
                end else if ((i > 0) && (CW'(i) > w_pos) && (SW'(i) <= w_last)) begin
                    r_fit[i] <= r_fit[(i > 0) ? i - 1 : 0];
                    r_pay[i] <= r_pay[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    assign o_result = r_res;

endmodule
